[src/iir6_direct_form2_q15_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sixth-order Q15 IIR filter
// Each macro builds one labeled concurrent assertion on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef IIR6_DIRECT_FORM2_Q15_TOP_MACROS_SVH
`define IIR6_DIRECT_FORM2_Q15_TOP_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds
`define IIR6_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds
`define IIR6_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/iir6_pkg.sv]
// ----------------------------------------------------------------------------
// iir6_pkg
// Types, constants and fixed-point helpers for the sixth-order Q15 IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iir6_pkg;

  localparam int TAPS      = 6;
  localparam int FRAC_BITS = 15;
  localparam int ROUND_HALF = 1 << 14;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FF_LOW  = 3'd0,
    CFG_FF_HIGH = 3'd1,
    CFG_FB_LOW  = 3'd2,
    CFG_FB_HIGH = 3'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Step counter landmarks: feedback products, b0*w, feedforward products
  localparam logic [3:0] STEP_FB_LAST  = 4'd5;
  localparam logic [3:0] STEP_FB_ACC   = 4'd6;
  localparam logic [3:0] STEP_B0       = 4'd7;
  localparam logic [3:0] STEP_FF_FIRST = 4'd8;
  localparam logic [3:0] STEP_FF_LAST  = 4'd13;
  localparam logic [3:0] STEP_LAST     = 4'd14;

  // Clamp an 18-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Round a Q30 product to Q15: add half, floor shift, saturate
  function automatic logic signed [15:0] q15_round(input logic signed [31:0] p);
    logic signed [32:0] r;
    r = $signed({p[31], p}) + 33'(ROUND_HALF);
    return sat16(r[32:FRAC_BITS]);
  endfunction

  // Saturating 16-bit add
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [17:0] s;
    s = $signed({{2{a[15]}}, a}) + $signed({{2{b[15]}}, b});
    return sat16(s);
  endfunction

endpackage

`default_nettype wire

[src/iir6_direct_form2_q15_top.sv]
// ----------------------------------------------------------------------------
// iir6_direct_form2_q15_top
// A request is taken only in the idle state; the run then steps through the
// feedback products, b0*w and the feedforward products on the single shared
// 16x16 multiplier that serves all thirteen products in turn, then a finish
// step. A new request is not taken before the last result is handed off. A
// stalled result holds the finish step.
// Reset (rst, synchronous): coefficients and the six-deep history clear to zero.
// Sixth-order direct form II IIR filter, Q15, with a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iir6_direct_form2_q15_top_macros.svh"

module iir6_direct_form2_q15_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // sample request
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] sample_in,
  // result
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      sample_out,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  // Coefficient registers
  logic [63:0] ff_low;
  logic [47:0] ff_high;
  logic [63:0] fb_low;
  logic [31:0] fb_high;

  iir6_pkg::state_t state, state_next;
  logic [3:0]  cnt, cnt_next;

  logic signed [15:0] hist [iir6_pkg::TAPS];
  logic signed [15:0] w_acc;
  logic signed [15:0] y_acc;
  logic signed [31:0] prod;

  logic signed [15:0] a_coef [iir6_pkg::TAPS];
  logic signed [15:0] b_coef [iir6_pkg::TAPS + 1];
  logic signed [15:0] mul_c;
  logic signed [15:0] mul_d;
  logic signed [15:0] prod_q;
  logic               in_take;
  logic               out_load;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_low  <= '0;
      ff_high <= '0;
      fb_low  <= '0;
      fb_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        iir6_pkg::CFG_FF_LOW:  ff_low  <= cfg_data;
        iir6_pkg::CFG_FF_HIGH: ff_high <= cfg_data[47:0];
        iir6_pkg::CFG_FB_LOW:  fb_low  <= cfg_data;
        iir6_pkg::CFG_FB_HIGH: fb_high <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients
  always_comb begin
    a_coef[0] = fb_low[15:0];
    a_coef[1] = fb_low[31:16];
    a_coef[2] = fb_low[47:32];
    a_coef[3] = fb_low[63:48];
    a_coef[4] = fb_high[15:0];
    a_coef[5] = fb_high[31:16];
    b_coef[0] = ff_low[15:0];
    b_coef[1] = ff_low[31:16];
    b_coef[2] = ff_low[47:32];
    b_coef[3] = ff_low[63:48];
    b_coef[4] = ff_high[15:0];
    b_coef[5] = ff_high[31:16];
    b_coef[6] = ff_high[47:32];
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_c = '0;
    mul_d = '0;
    if (state == iir6_pkg::ST_RUN) begin
      if (cnt <= iir6_pkg::STEP_FB_LAST) begin
        mul_c = -a_coef[cnt[2:0]];
        mul_d = hist[cnt[2:0]];
      end else if (cnt == iir6_pkg::STEP_B0) begin
        mul_c = b_coef[0];
        mul_d = w_acc;
      end else if (cnt >= iir6_pkg::STEP_FF_FIRST && cnt <= iir6_pkg::STEP_FF_LAST) begin
        mul_c = b_coef[3'(cnt[2:0] + 3'd1)];
        mul_d = hist[cnt[2:0]];
      end
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_c * mul_d;
  end

  assign prod_q = iir6_pkg::q15_round(prod);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iir6_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state, handshake outputs
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      iir6_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = iir6_pkg::ST_RUN;
          cnt_next   = '0;
        end
      end
      iir6_pkg::ST_RUN: begin
        cnt_next = cnt + 4'd1;
        if (cnt == iir6_pkg::STEP_LAST) begin
          state_next = iir6_pkg::ST_FINISH;
        end
      end
      iir6_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = iir6_pkg::ST_IDLE;
        end
      end
      default: state_next = iir6_pkg::ST_IDLE;
    endcase
  end

  // Accumulate w over feedback steps, then y over feedforward steps
  always_ff @(posedge clk) begin
    if (in_take) begin
      w_acc <= sample_in;
    end else if (state == iir6_pkg::ST_RUN) begin
      if (cnt >= 4'd1 && cnt <= iir6_pkg::STEP_FB_ACC) begin
        w_acc <= iir6_pkg::sat_add(w_acc, prod_q);
      end
      if (cnt == iir6_pkg::STEP_FF_FIRST) begin
        y_acc <= prod_q;
      end else if (cnt > iir6_pkg::STEP_FF_FIRST && cnt <= iir6_pkg::STEP_LAST) begin
        y_acc <= iir6_pkg::sat_add(y_acc, prod_q);
      end
    end
  end

  // Advance history when the result is handed off
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iir6_pkg::TAPS; i++) begin
        hist[i] <= '0;
      end
    end else if (out_load) begin
      for (int i = iir6_pkg::TAPS - 1; i > 0; i--) begin
        hist[i] <= hist[i - 1];
      end
      hist[0] <= w_acc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= y_acc;
    end
  end

  // Checks
  `IIR6_ASSERT_NEXT(a_start_run, in_valid && in_ready,
    state == iir6_pkg::ST_RUN && cnt == 4'd0, "accepted request did not start run")
  `IIR6_ASSERT_SAME(a_rose_from_finish, $rose(out_valid),
    $past(state) == iir6_pkg::ST_FINISH, "result appeared without finish step")
  `IIR6_ASSERT_NEXT(a_load_value, out_load,
    out_valid && sample_out == $past(y_acc), "result register did not take y")
  `IIR6_ASSERT_SAME(a_cnt_bound, state == iir6_pkg::ST_RUN,
    cnt <= iir6_pkg::STEP_LAST, "step counter overran")

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: sixth-order direct form II Q15 IIR filter testbench
// Drives sample requests and coefficient writes through valid/ready channels.
// A scoreboard class mirrors the filter's history and coefficients, predicts
// each filtered sample, and checks results in order. A directed pass covers
// the saturation corners, then random samples run over several coefficient
// sets with random idling on both sides, except in the last two sets.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int HIST_DEPTH  = 6;
  localparam int LIMIT       = 500000;
  localparam int SETTLE      = 24;
  localparam int PHASE_ITEMS = 240;

  // Spare register indexes: writes there must be ignored
  localparam logic [2:0] CFG_SPARE_LO = 3'd4;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {
    MIX_RANDOM,
    MIX_GENTLE,
    MIX_MAX,
    MIX_MINUS_ONE
  } coef_mix_t;

  localparam coef_mix_t PLAN [6] = '{MIX_RANDOM, MIX_GENTLE, MIX_MAX,
                                     MIX_GENTLE, MIX_MINUS_ONE, MIX_RANDOM};

  // Mirror of the filter: coefficients, w history, and pending outputs
  class iir_predictor;
    logic [63:0]        ff_low;
    logic [47:0]        ff_high;
    logic [63:0]        fb_low;
    logic [31:0]        fb_high;
    logic signed [15:0] w_hist [HIST_DEPTH];
    logic signed [15:0] expected_out [$];
    int                 errors;

    function new();
      ff_low  = '0;
      ff_high = '0;
      fb_low  = '0;
      fb_high = '0;
      foreach (w_hist[i]) w_hist[i] = '0;
      errors  = 0;
    endfunction

    // Keep each register masked to its width; drop spare indexes
    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        iir6_pkg::CFG_FF_LOW:  ff_low  = data;
        iir6_pkg::CFG_FF_HIGH: ff_high = data[47:0];
        iir6_pkg::CFG_FB_LOW:  fb_low  = data;
        iir6_pkg::CFG_FB_HIGH: fb_high = data[31:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] coef_b(int k);
      if (k < 4) return ff_low[16*k +: 16];
      return ff_high[16*(k-4) +: 16];
    endfunction

    function logic signed [15:0] coef_a(int k);
      if (k <= 4) return fb_low[16*(k-1) +: 16];
      return fb_high[16*(k-5) +: 16];
    endfunction

    function logic signed [15:0] clamp16(logic signed [39:0] v);
      if (v > 40'sd32767) return 16'sh7fff;
      if (v < -40'sd32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Q15 product: add half an LSB, floor shift, saturate
    function logic signed [15:0] q15_product(logic signed [15:0] c, logic signed [15:0] v);
      logic signed [39:0] p;
      p = c * v;
      p = p + 40'sd16384;
      p = p >>> 15;
      return clamp16(p);
    endfunction

    function logic signed [15:0] sat_sum(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [39:0] s;
      s = a + b;
      return clamp16(s);
    endfunction

    // Run one sample through the recursion and queue the filtered output
    function void note_sample(logic signed [15:0] x);
      logic signed [15:0] w;
      logic signed [15:0] y;
      logic signed [15:0] na;
      int k;
      w = x;
      for (k = 1; k <= HIST_DEPTH; k++) begin
        na = coef_a(k);
        // negating the most negative coefficient wraps to itself
        if (na != 16'sh8000) na = -na;
        w = sat_sum(w, q15_product(na, w_hist[k-1]));
      end
      y = q15_product(coef_b(0), w);
      for (k = 1; k <= HIST_DEPTH; k++) begin
        y = sat_sum(y, q15_product(coef_b(k), w_hist[k-1]));
      end
      for (k = HIST_DEPTH - 1; k > 0; k--) w_hist[k] = w_hist[k-1];
      w_hist[0] = w;
      expected_out.push_back(y);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_filtered(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no sample pending", got));
      end else begin
        want = expected_out.pop_front();
        if (got !== want)
          report_mismatch($sformatf("sample_out %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] sample_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] sample_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;

  iir_predictor book;
  int           send_idle_pct = 17;
  int           recv_idle_pct = 54;
  int unsigned  cycle_count = 0;

  iir6_direct_form2_q15_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("iir6_direct_form2_q15_top verification failed");
      $finish;
    end
  end

  // Stall the result side at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_filtered(sample_out);
  end

  // Offer one sample request, after a random gap, and hold it until accepted
  task automatic push_sample(input logic signed [15:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    sample_in = v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_sample(v);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop the request line and wait until the filter has drained
  task automatic settle();
    in_valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] gentle_taps();
    logic [63:0] v;
    for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'($urandom_range(0, 4096)) - 16'd2048;
    return v;
  endfunction

  // Mostly full-range samples, with extremes and small values mixed in
  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    if (r < 35) return 16'($urandom_range(0, 512)) - 16'd256;
    return 16'($urandom);
  endfunction

  task automatic load_mix(input coef_mix_t mix);
    logic [63:0] ffl;
    logic [63:0] ffh;
    logic [63:0] fbl;
    logic [63:0] fbh;
    ffl = {$urandom, $urandom};
    ffh = {$urandom, $urandom};
    fbl = {$urandom, $urandom};
    fbh = {$urandom, $urandom};
    case (mix)
      MIX_GENTLE: begin
        fbl = gentle_taps();
        fbh = gentle_taps();
      end
      MIX_MAX: begin
        ffl = {4{16'h7fff}};
        ffh = {4{16'h7fff}};
        fbl = {4{16'h7fff}};
        fbh = {4{16'h7fff}};
      end
      MIX_MINUS_ONE: begin
        ffl = '1;
        ffh = '1;
        fbl = '1;
        fbh = '1;
      end
      default: ;
    endcase
    write_cfg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), {$urandom, $urandom});
    write_cfg(iir6_pkg::CFG_FF_LOW, ffl);
    write_cfg(iir6_pkg::CFG_FF_HIGH, ffh);
    write_cfg(iir6_pkg::CFG_FB_LOW, fbl);
    write_cfg(iir6_pkg::CFG_FB_HIGH, fbh);
  endtask

  initial begin
    logic signed [15:0] corner_items [8];
    logic signed [15:0] echo_items [6];
    int p;
    int i;
    corner_items = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000,
                     16'shffff, 16'sh0001, 16'sh7fff, 16'sh8000};
    echo_items   = '{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh4000, 16'sh0000};
    book      = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    cfg_valid = 1'b0;
    cfg_index = iir6_pkg::CFG_FF_LOW;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero coefficients out of reset: every output is zero
    push_sample(16'sh7fff);
    push_sample(16'sh8000);
    settle();

    // Most negative feedback taps but the last (negation wraps), b0 at the most negative value
    write_cfg(iir6_pkg::CFG_FF_LOW, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    write_cfg(iir6_pkg::CFG_FF_HIGH, {16'ha5a5, 16'hffff, 16'h7fff, 16'h8000});
    write_cfg(iir6_pkg::CFG_FB_LOW, {4{16'h8000}});
    write_cfg(iir6_pkg::CFG_FB_HIGH, {32'h5a5a5a5a, 16'h7fff, 16'h8000});
    write_cfg(CFG_SPARE_HI, '1);
    foreach (corner_items[j]) push_sample(corner_items[j]);
    settle();

    // Near-unity gain with a single half-weight echo
    write_cfg(iir6_pkg::CFG_FF_LOW, {48'h0, 16'h7fff});
    write_cfg(iir6_pkg::CFG_FF_HIGH, '0);
    write_cfg(iir6_pkg::CFG_FB_LOW, {48'h0, 16'h4000});
    write_cfg(iir6_pkg::CFG_FB_HIGH, '0);
    foreach (echo_items[j]) push_sample(echo_items[j]);
    settle();

    // Random samples over several coefficient sets and idling regimes
    for (p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 54;
      end else if (p < 4) begin
        send_idle_pct = 54;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_mix(PLAN[p]);
      for (i = 0; i < PHASE_ITEMS; i++) push_sample(pick_sample());
      settle();
    end

    if (book.errors == 0) begin
      $display("iir6_direct_form2_q15_top verification clean");
    end else begin
      $display("iir6_direct_form2_q15_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/iir6_pkg.sv
src/iir6_direct_form2_q15_top.sv
bench/tb.sv
